[design/srt_pkg.sv]
`default_nettype none
package srt_pkg;
    localparam int Capacity = 64;
    localparam int AddrW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);
    localparam int QueueDepth = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_REMOVED = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // one table entry: name key and packed date
    typedef struct packed {
        logic [63:0] name_key;
        logic [11:0] birth_year;
        logic [3:0]  birth_month;
        logic [4:0]  birth_day;
    } rec_t;

    // command word passed from front to back
    typedef struct packed {
        logic operation;
        rec_t rec;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT_UP, S_SHIFT_DOWN, S_WRITE, S_DONE
    } state_t;
endpackage
`default_nettype wire

[design/srt_front.sv]
`default_nettype none
// Input stage: registers words from the input channel into a short queue.
module srt_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire srt_pkg::cmd_t s_cmd,
    output logic               q_valid,
    input  wire logic          q_ready,
    output srt_pkg::cmd_t      q_cmd
);
    localparam int PtrW = $clog2(srt_pkg::QueueDepth);

    srt_pkg::cmd_t         mem_reg [srt_pkg::QueueDepth];
    logic [PtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]         fill_reg;
    logic                  push, pop;

    assign s_ready = (fill_reg != PtrW'(0) + (PtrW+1)'(srt_pkg::QueueDepth));
    assign q_valid = (fill_reg != '0);
    assign q_cmd = mem_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            fill_reg <= fill_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (PtrW+1)'(srt_pkg::QueueDepth)) else $error("queue overflow");
    pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> !pop) else $error("pop from empty queue");
    fill_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill level slip");
endmodule
`default_nettype wire

[design/srt_back.sv]
`default_nettype none
// Table engine: scans and shifts the sorted memory one entry a cycle.
module srt_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire srt_pkg::cmd_t q_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_status,
    output logic [srt_pkg::CountW-1:0] m_count
);
    localparam int AW = srt_pkg::AddrW;
    localparam int CW = srt_pkg::CountW;

    srt_pkg::rec_t  mem [srt_pkg::Capacity];
    srt_pkg::rec_t  rd_data_reg;

    srt_pkg::state_t state_reg, state_next;
    srt_pkg::cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      status_reg, status_next;

    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    srt_pkg::rec_t   wr_data;
    logic            match;

    // memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    assign match = (rd_data_reg.name_key == cmd_reg.rec.name_key)
                && (rd_data_reg.birth_day == cmd_reg.rec.birth_day)
                && (rd_data_reg.birth_year == cmd_reg.rec.birth_year);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srt_pkg::S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        status_reg <= status_next;
    end

    // Insert: read idx-1, compare day, move it up or write the new record.
    // Remove: read idx, search for match, then pull later entries down.
    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        out_valid_next = out_valid_reg;
        status_next = status_reg;
        q_ready = 1'b0;
        rd_en = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        wr_en = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = cmd_reg.rec;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        case (state_reg)
            srt_pkg::S_IDLE: begin
                q_ready = !out_valid_reg;
                if (q_valid && !out_valid_reg) begin
                    cmd_next = q_cmd;
                    idx_next = count_reg;
                    if (q_cmd.operation == srt_pkg::OP_INSERT) begin
                        if (count_reg == CW'(srt_pkg::Capacity)) begin
                            status_next = srt_pkg::ST_FULL;
                            state_next = srt_pkg::S_DONE;
                        end else if (count_reg == '0) begin
                            state_next = srt_pkg::S_WRITE;
                        end else begin
                            rd_en = 1'b1;
                            rd_addr = AW'(count_reg - CW'(1));
                            state_next = srt_pkg::S_SHIFT_UP;
                        end
                    end else begin
                        idx_next = '0;
                        if (count_reg == '0) begin
                            status_next = srt_pkg::ST_NOT_FOUND;
                            state_next = srt_pkg::S_DONE;
                        end else begin
                            rd_en = 1'b1;
                            rd_addr = '0;
                            state_next = srt_pkg::S_SCAN;
                        end
                    end
                end
            end
            srt_pkg::S_SHIFT_UP: begin
                // rd_data_reg holds entry idx-1
                if (cmd_reg.rec.birth_day < rd_data_reg.birth_day) begin
                    wr_en = 1'b1;
                    wr_data = rd_data_reg;
                    idx_next = idx_reg - CW'(1);
                    if (idx_reg == CW'(1)) begin
                        state_next = srt_pkg::S_WRITE;
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = AW'(idx_reg - CW'(2));
                    end
                end else begin
                    state_next = srt_pkg::S_WRITE;
                end
            end
            srt_pkg::S_WRITE: begin
                wr_en = 1'b1;
                count_next = count_reg + CW'(1);
                status_next = srt_pkg::ST_INSERTED;
                state_next = srt_pkg::S_DONE;
            end
            srt_pkg::S_SCAN: begin
                // rd_data_reg holds entry idx
                if (match) begin
                    if (idx_reg + CW'(1) == count_reg) begin
                        count_next = count_reg - CW'(1);
                        status_next = srt_pkg::ST_REMOVED;
                        state_next = srt_pkg::S_DONE;
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = AW'(idx_reg + CW'(1));
                        state_next = srt_pkg::S_SHIFT_DOWN;
                    end
                end else if (idx_reg + CW'(1) == count_reg) begin
                    status_next = srt_pkg::ST_NOT_FOUND;
                    state_next = srt_pkg::S_DONE;
                end else begin
                    idx_next = idx_reg + CW'(1);
                    rd_en = 1'b1;
                    rd_addr = AW'(idx_reg + CW'(1));
                end
            end
            srt_pkg::S_SHIFT_DOWN: begin
                // rd_data_reg holds entry idx+1, move it to idx
                wr_en = 1'b1;
                wr_data = rd_data_reg;
                idx_next = idx_reg + CW'(1);
                if (idx_reg + CW'(2) == count_reg) begin
                    count_next = count_reg - CW'(1);
                    status_next = srt_pkg::ST_REMOVED;
                    state_next = srt_pkg::S_DONE;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = AW'(idx_reg + CW'(2));
                end
            end
            srt_pkg::S_DONE: begin
                out_valid_next = 1'b1;
                state_next = srt_pkg::S_IDLE;
            end
            default: state_next = srt_pkg::S_IDLE;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_status = status_reg;
    assign m_count = count_reg;

    count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(srt_pkg::Capacity)) else $error("count above capacity");
    count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
        (($past(state_reg) == srt_pkg::S_WRITE) || ($past(state_reg) == srt_pkg::S_SCAN)
         || ($past(state_reg) == srt_pkg::S_SHIFT_DOWN))) else $error("stray count change");
    result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_count)))
        else $error("result dropped");
endmodule
`default_nettype wire

[design/sorted_record_table.sv]
`default_nettype none
// Sorted record table: holds up to 64 date records ordered by day, stable among
// equal days. Insert (operation 0) places the record after all entries of equal or
// smaller day; remove (operation 1) deletes the first entry matching name key, day
// and year. Each word gives one result: status and count held afterwards. Entries
// live in a single-port-write, registered-read memory and are moved one per cycle.
// An insert reads entries from the top down and shifts those of larger day up before
// writing the record; a remove scans from entry 0 and then pulls later entries down.
// The engine takes the next word once the result has left, and a small input queue
// accepts further words meanwhile. No clearing pass is needed.
module sorted_record_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: operation[0], name_key[64:1], birth_day[69:65], birth_month[73:70],
    // birth_year[85:74], zero fill to 88
    input  wire logic [87:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: status[1:0], entry_count[8:2], zero fill to 16
    output logic [15:0]      m_tdata
);
    srt_pkg::cmd_t s_cmd, q_cmd;
    logic          q_valid, q_ready;
    logic [1:0]    status;
    logic [srt_pkg::CountW-1:0] count;

    assign s_cmd.operation = s_tdata[0];
    assign s_cmd.rec.name_key = s_tdata[64:1];
    assign s_cmd.rec.birth_day = s_tdata[69:65];
    assign s_cmd.rec.birth_month = s_tdata[73:70];
    assign s_cmd.rec.birth_year = s_tdata[85:74];

    srt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready), .s_cmd(s_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    srt_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_status(status), .m_count(count)
    );

    assign m_tdata = {7'd0, count, status};
endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    sorted_record_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    typedef struct {
        logic [1:0] status;
        logic [6:0] count;
    } outcome_t;

    // shadow copy of the table
    srt_pkg::rec_t shadow_tab[srt_pkg::Capacity];
    int       shadow_held;
    outcome_t outcome_q[$];
    int       err_cnt = 0;
    bit       stim_done = 0;
    bit       driving = 0;

    // directed table: op, key, day, month, year, check_given, status, count
    typedef struct {
        logic        op;
        logic [63:0] key;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        bit          given;
        logic [1:0]  status;
        logic [6:0]  count;
    } row_t;

    function automatic outcome_t table_apply(logic op, srt_pkg::rec_t r);
        outcome_t o;
        int i;
        int pos;
        pos = -1;
        if (op == srt_pkg::OP_INSERT) begin
            if (shadow_held >= srt_pkg::Capacity) begin
                o.status = srt_pkg::ST_FULL;
            end else begin
                i = shadow_held;
                while (i > 0 && r.birth_day < shadow_tab[i-1].birth_day) begin
                    shadow_tab[i] = shadow_tab[i-1];
                    i--;
                end
                shadow_tab[i] = r;
                shadow_held++;
                o.status = srt_pkg::ST_INSERTED;
            end
        end else begin
            for (i = 0; i < shadow_held; i++)
                if (pos < 0 && shadow_tab[i].name_key == r.name_key &&
                    shadow_tab[i].birth_day == r.birth_day &&
                    shadow_tab[i].birth_year == r.birth_year)
                    pos = i;
            if (pos >= 0) begin
                for (i = pos; i + 1 < shadow_held; i++) shadow_tab[i] = shadow_tab[i+1];
                shadow_held--;
                o.status = srt_pkg::ST_REMOVED;
            end else begin
                o.status = srt_pkg::ST_NOT_FOUND;
            end
        end
        o.count = shadow_held[6:0];
        return o;
    endfunction

    // drop tvalid once the last word has gone
    task automatic release_input();
        if (driving) begin
            s_tvalid <= 1'b0;
            driving = 0;
        end
    endtask

    task automatic send_word(logic op, srt_pkg::rec_t r, bit given, logic [1:0] st,
                             logic [6:0] cnt);
        outcome_t o;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            release_input();
            repeat (gap) @(posedge aclk);
        end
        o = table_apply(op, r);
        if (given && (o.status !== st || o.count !== cnt)) begin
            $error("table row disagrees: status %0d/%0d count %0d/%0d",
                   st, o.status, cnt, o.count);
            err_cnt++;
        end
        outcome_q.push_back(o);
        s_tdata <= {2'b0, r.birth_year, r.birth_month, r.birth_day, r.name_key, op};
        s_tvalid <= 1'b1;
        driving = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // result checking
    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                err_cnt++;
            end else begin
                e = outcome_q.pop_front();
                if (m_tdata[1:0] !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, m_tdata[1:0]);
                    err_cnt++;
                end
                if (m_tdata[8:2] !== e.count) begin
                    $error("entry_count: expected %0d actual %0d", e.count, m_tdata[8:2]);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                  : $urandom_range(1, 3);
                repeat (gap - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 80)) @(posedge aclk);
            end
        end
    end

    // stimulus
    initial begin
        row_t rows[$];
        srt_pkg::rec_t r;
        logic [63:0] keys[8];
        srt_pkg::rec_t pick;
        int k;
        shadow_held = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = '{
            '{srt_pkg::OP_REMOVE, 64'h0, 5'd1, 4'd1, 12'd0, 1, srt_pkg::ST_NOT_FOUND, 7'd0},
            '{srt_pkg::OP_INSERT, '1, 5'd31, 4'd15, 12'hFFF, 1, srt_pkg::ST_INSERTED, 7'd1},
            '{srt_pkg::OP_INSERT, 64'h0, 5'd0, 4'd0, 12'd0, 1, srt_pkg::ST_INSERTED, 7'd2},
            '{srt_pkg::OP_INSERT, 64'h4A4F484E, 5'd15, 4'd13, 12'd1999, 1,
              srt_pkg::ST_INSERTED, 7'd3},
            '{srt_pkg::OP_INSERT, 64'h4A4F484E, 5'd15, 4'd2, 12'd1999, 1,
              srt_pkg::ST_INSERTED, 7'd4},
            '{srt_pkg::OP_INSERT, 64'h5555, 5'd15, 4'd5, 12'd2000, 0, 0, 0},
            '{srt_pkg::OP_REMOVE, 64'h4A4F484E, 5'd15, 4'd9, 12'd1999, 1,
              srt_pkg::ST_REMOVED, 7'd4},
            '{srt_pkg::OP_REMOVE, 64'h4A4F484E, 5'd15, 4'd9, 12'd1998, 1,
              srt_pkg::ST_NOT_FOUND, 7'd4},
            '{srt_pkg::OP_REMOVE, 64'h4A4F484F, 5'd15, 4'd2, 12'd1999, 1,
              srt_pkg::ST_NOT_FOUND, 7'd4},
            '{srt_pkg::OP_REMOVE, 64'h4A4F484E, 5'd14, 4'd2, 12'd1999, 1,
              srt_pkg::ST_NOT_FOUND, 7'd4},
            '{srt_pkg::OP_REMOVE, '1, 5'd31, 4'd0, 12'hFFF, 1, srt_pkg::ST_REMOVED, 7'd3},
            '{srt_pkg::OP_REMOVE, 64'h0, 5'd0, 4'd7, 12'd0, 1, srt_pkg::ST_REMOVED, 7'd2},
            '{srt_pkg::OP_INSERT, 64'hAAAA_5555_AAAA_5555, 5'd10, 4'd10, 12'hAAA, 0, 0, 0},
            '{srt_pkg::OP_INSERT, 64'h5555_AAAA_5555_AAAA, 5'd21, 4'd5, 12'h555, 0, 0, 0}
        };
        foreach (rows[i]) begin
            r = '{rows[i].key, rows[i].year, rows[i].month, rows[i].day};
            send_word(rows[i].op, r, rows[i].given, rows[i].status, rows[i].count);
        end

        // fill to capacity, then refused inserts
        while (shadow_held < srt_pkg::Capacity) begin
            r = '{{$urandom, $urandom}, 12'($urandom), 4'($urandom), 5'($urandom)};
            send_word(srt_pkg::OP_INSERT, r, 0, 0, 0);
        end
        r = '{64'h1, 12'd1, 4'd1, 5'd1};
        send_word(srt_pkg::OP_INSERT, r, 1, srt_pkg::ST_FULL, 7'd64);
        send_word(srt_pkg::OP_INSERT, r, 1, srt_pkg::ST_FULL, 7'd64);
        // remove the last entry of the sorted table
        send_word(srt_pkg::OP_REMOVE, shadow_tab[srt_pkg::Capacity-1], 1,
                  srt_pkg::ST_REMOVED, 7'd63);

        // pause until every expected result has come
        release_input();
        while (outcome_q.size() != 0) @(posedge aclk);

        // random part: small key pool so removes often hit and duplicates form
        foreach (keys[i]) keys[i] = {$urandom, $urandom};
        for (int n = 0; n < 1280; n++) begin
            if (n % 300 == 150) begin
                release_input();
                while (outcome_q.size() != 0) @(posedge aclk);
            end
            k = $urandom_range(0, 99);
            if (k < 40 && shadow_held > 0) begin
                pick = shadow_tab[$urandom_range(0, shadow_held - 1)];
                pick.birth_month = 4'($urandom);
                send_word(srt_pkg::OP_REMOVE, pick, 0, 0, 0);
            end else if (k < 50) begin
                r = '{keys[$urandom_range(0, 7)], 12'($urandom_range(0, 3)),
                      4'($urandom), 5'($urandom_range(0, 3))};
                send_word(srt_pkg::OP_REMOVE, r, 0, 0, 0);
            end else begin
                r = '{($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                  : keys[$urandom_range(0, 7)],
                      ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3)),
                      4'($urandom), ($urandom_range(0, 1) == 0) ? 5'($urandom)
                                                                : 5'($urandom_range(0, 3))};
                send_word(srt_pkg::OP_INSERT, r, 0, 0, 0);
            end
        end
        release_input();
        stim_done = 1;
    end

    // end of run
    initial begin
        wait (stim_done);
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
design/srt_pkg.sv
design/srt_front.sv
design/srt_back.sv
design/sorted_record_table.sv
test/tb_top.sv
